>>> sv/adlp_pkg.sv
// shared constants and types for the ascii decimal line parser
`default_nettype none

package adlp_pkg;

  localparam int unsigned LINE_CAPACITY = 10;
  localparam int unsigned CNT_W         = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned MAG_W         = 30;
  localparam int unsigned VALUE_W       = 31;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CHAR_VT      = 8'd11;
  localparam logic [BYTE_W-1:0] CHAR_FF      = 8'd12;
  localparam logic [BYTE_W-1:0] CHAR_CR      = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'd43;
  localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'd45;
  localparam logic [BYTE_W-1:0] CHAR_DIGIT0  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_DIGIT9  = 8'd57;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_STOP
  } phase_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    phase_e           phase;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } line_state_t;

  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] value;
  } line_result_t;

  localparam line_state_t LINE_CLEAR = '{
    count: '0,
    phase: PH_SKIP,
    neg:   1'b0,
    mag:   '0
  };

endpackage

`default_nettype wire

>>> sv/adlp_step.sv
// per-byte next-state and result logic of the line parser
`default_nettype none

module adlp_step (
  input  adlp_pkg::line_state_t           cur_i,
  input  logic [adlp_pkg::BYTE_W-1:0]     rx_byte_i,
  output adlp_pkg::line_state_t           nxt_o,
  output adlp_pkg::line_result_t          res_o
);
  import adlp_pkg::*;

  logic             is_digit;
  logic             is_white;
  logic             is_sign;
  logic [CNT_W:0]   cnt_inc;
  logic [MAG_W-1:0] mag_next;

  assign is_digit = (rx_byte_i >= CHAR_DIGIT0) && (rx_byte_i <= CHAR_DIGIT9);
  assign is_white = (rx_byte_i == CHAR_SPACE) || (rx_byte_i == CHAR_TAB) ||
                    (rx_byte_i == CHAR_VT) || (rx_byte_i == CHAR_FF) ||
                    (rx_byte_i == CHAR_CR);
  assign is_sign  = (rx_byte_i == CHAR_PLUS) || (rx_byte_i == CHAR_MINUS);
  assign cnt_inc  = (CNT_W + 1)'(cur_i.count) + (CNT_W + 1)'(1);

  // mag * 10 + digit, wrapped to the magnitude width
  assign mag_next = {cur_i.mag[MAG_W-4:0], 3'b000} + {cur_i.mag[MAG_W-2:0], 1'b0} +
                    MAG_W'(rx_byte_i[3:0]);

  always_comb begin
    nxt_o       = cur_i;
    res_o.emit  = 1'b0;
    res_o.value = cur_i.neg ? (VALUE_W'(0) - {1'b0, cur_i.mag}) : {1'b0, cur_i.mag};
    if (rx_byte_i == NEWLINE_BYTE) begin
      nxt_o      = LINE_CLEAR;
      res_o.emit = (cur_i.count < CNT_W'(LINE_CAPACITY));
    end else if (cur_i.count < CNT_W'(LINE_CAPACITY)) begin
      nxt_o.count = cnt_inc[CNT_W-1:0];
      // the character that fills the line is never parsed
      if (cnt_inc < (CNT_W + 1)'(LINE_CAPACITY)) begin
        priority if (cur_i.phase == PH_SKIP && is_white) begin
          nxt_o.phase = PH_SKIP;
        end else if (cur_i.phase == PH_SKIP && is_sign) begin
          nxt_o.neg   = (rx_byte_i == CHAR_MINUS);
          nxt_o.phase = PH_SIGN;
        end else if (cur_i.phase == PH_STOP) begin
          nxt_o.phase = PH_STOP;
        end else if (is_digit) begin
          nxt_o.mag   = mag_next;
          nxt_o.phase = PH_DIGITS;
        end else begin
          nxt_o.phase = PH_STOP;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/ascii_decimal_line_parser_core.sv
// ascii decimal line parser: bytes in, one signed value per completed line out
//
// input channel: one received byte per request on rx_byte_i (in_valid_i/in_ready_o).
// output channel: one signed 31-bit value per accepted line on line_value_o
// (out_valid_o/out_ready_i).
// each byte updates the line state in the cycle it is accepted; a newline that
// ends a line shorter than LINE_CAPACITY loads the result register at the same
// edge, so the value is offered in the cycle after the newline is accepted.
// throughput is one byte per cycle while no waiting result stalls the input, set
// by the single multiply-by-ten-and-add in the step logic. a line that reaches
// LINE_CAPACITY characters gives no result; parsing resumes after the next newline.
// reset clears the line state and empties the result register.
// while a result waits and out_ready_i is low, in_ready_o is low; with
// out_ready_i high a new byte is taken in the same cycle the result leaves.
`default_nettype none

module ascii_decimal_line_parser_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [adlp_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [adlp_pkg::VALUE_W-1:0] line_value_o
);
  import adlp_pkg::*;

  line_state_t        state_q;
  line_state_t        state_d;
  line_result_t       res;
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               in_fire;

  adlp_step u_step (
    .cur_i     (state_q),
    .rx_byte_i (rx_byte_i),
    .nxt_o     (state_d),
    .res_o     (res)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LINE_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res.emit) begin
      out_value_q <= res.value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_value_o = out_value_q;

endmodule

`default_nettype wire

>>> sv/adlp_checker.sv
// port-level checks for the ascii decimal line parser, bound to the top level
`default_nettype none

module adlp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [adlp_pkg::BYTE_W-1:0]       rx_byte_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [adlp_pkg::VALUE_W-1:0] line_value_o
);
  import adlp_pkg::*;

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(line_value_o))
    else $error("result value changed while stalled");

  // an empty result register never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending result");

  // only a newline request can create a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (rx_byte_i != NEWLINE_BYTE) &&
    (!out_valid_o || out_ready_i) |=> !out_valid_o)
    else $error("result produced without a newline");

endmodule

bind ascii_decimal_line_parser_core adlp_checker u_adlp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .rx_byte_i    (rx_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .line_value_o (line_value_o)
);

`default_nettype wire
